[rtl/crc8sfc_pkg.sv]
// ----------------------------------------------------------------------------
// crc8sfc_pkg
// Shared types, constants and the crc-8 byte update for the status frame
// checker.
// ----------------------------------------------------------------------------
package crc8sfc_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 8;
  localparam int HELD_BYTES  = FRAME_BYTES - 1;
  localparam int CNT_W       = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);

  // crc-8 polynomial x^8 + x^2 + x + 1, msb first, init zero
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // output bus widths
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USER_W = 1;

  // completed frame as it travels from front to back
  typedef struct packed {
    logic [HELD_BYTES-1:0][7:0] bytes;
    logic                       ok;
  } frame_rec_t;

  // push side of the frame queue
  typedef struct packed {
    logic       push;
    frame_rec_t rec;
  } q_push_t;

  // one byte through the crc register, bit by bit
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

[rtl/crc8sfc_front.sv]
// ----------------------------------------------------------------------------
// crc8sfc_front
// Byte intake: tracks the frame position, runs the crc and holds the first
// seven bytes; pushes one frame record on each closing byte.
// ----------------------------------------------------------------------------
module crc8sfc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  output crc8sfc_pkg::q_push_t q_in
);
  import crc8sfc_pkg::*;

  logic [CNT_W-1:0]           byte_count;
  logic [CNT_W-1:0]           byte_count_next;
  logic [7:0]                 running_crc;
  logic [7:0]                 running_crc_next;
  logic [HELD_BYTES-1:0][7:0] held_bytes;
  logic [CNT_W-1:0]           pos;
  logic [7:0]                 crc_base;
  logic                       is_last;

  // a start flag forces byte zero with a fresh crc
  always_comb begin
    pos      = frame_start ? '0 : byte_count;
    crc_base = frame_start ? CRC_INIT : running_crc;
    is_last  = (pos == LAST_IDX);
  end

  // next count and crc
  always_comb begin
    byte_count_next  = byte_count;
    running_crc_next = running_crc;
    if (take) begin
      if (is_last) begin
        byte_count_next  = '0;
        running_crc_next = CRC_INIT;
      end else begin
        byte_count_next  = pos + CNT_W'(1);
        running_crc_next = crc8_byte(crc_base, rx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_crc <= CRC_INIT;
    end else begin
      byte_count  <= byte_count_next;
      running_crc <= running_crc_next;
    end
  end

  // held payload bytes, no reset
  always_ff @(posedge clk) begin
    if (take && !is_last) begin
      held_bytes[pos] <= rx_byte;
    end
  end

  // frame record toward the queue
  always_comb begin
    q_in.push      = take && is_last;
    q_in.rec.bytes = held_bytes;
    q_in.rec.ok    = (rx_byte == crc_base);
  end

endmodule

[rtl/crc8sfc_queue.sv]
// ----------------------------------------------------------------------------
// crc8sfc_queue
// Two-entry frame queue between intake and result formatting.
// ----------------------------------------------------------------------------
module crc8sfc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  crc8sfc_pkg::q_push_t   q_in,
  output logic                   full,
  output logic                   not_empty,
  input  logic                   pop,
  output crc8sfc_pkg::frame_rec_t rd_rec
);
  import crc8sfc_pkg::*;

  frame_rec_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_pop;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign do_pop    = pop && not_empty;
  assign rd_rec    = mem[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (q_in.push) begin
      mem[wr_ptr] <= q_in.rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (q_in.push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({q_in.push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[rtl/crc8sfc_back.sv]
// ----------------------------------------------------------------------------
// crc8sfc_back
// Result side: unpacks a queued frame into the output fields and holds it
// in the output register until the transaction completes.
// ----------------------------------------------------------------------------
module crc8sfc_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_not_empty,
  input  crc8sfc_pkg::frame_rec_t              q_rec,
  output logic                                 q_pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [crc8sfc_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [crc8sfc_pkg::OUT_USER_W-1:0]   m_tuser
);
  import crc8sfc_pkg::*;

  logic [HELD_BYTES-1:0][7:0] b;
  logic [OUT_DATA_W-1:0]      data_next;

  // output register free or draining this cycle
  assign q_pop = q_not_empty && (!m_tvalid || m_tready);

  // field packing, all zero on a crc mismatch
  always_comb begin
    b = q_rec.ok ? q_rec.bytes : '0;
    data_next = {6'b0, b[3][6], b[3][7], b[3], b[4],
                 b[6], b[5], b[4], b[3], b[2], b[1], b[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= data_next;
      m_tuser <= OUT_USER_W'(q_rec.ok);
    end
  end

endmodule

[rtl/crc8_status_frame_checker_top.sv]
// ----------------------------------------------------------------------------
// crc8_status_frame_checker_top
// Checks 8-byte status frames against a trailing crc-8 and emits the
// unpacked fields once per frame.
// ----------------------------------------------------------------------------
// Usage:
//   slave side takes one received byte per transaction; s_tuser[0] marks the
//   first byte of a frame and restarts the byte count and the crc. Without a
//   start mark, the byte after a closing byte is taken as byte 0.
//   master side gives one transaction per eighth byte: the seven payload
//   bytes, the big-endian word of bytes 3 and 4, the valve and override bits
//   and the crc flag in m_tuser[0]; every field is zero when the crc fails.
//   A result goes into the queue when its closing byte is accepted, and
//   from there into the output register once that register is free or draining.
//   Throughput: one byte per cycle while s_tready is high; crc runs bitwise.
//   A stalled receiver fills the two-entry queue; s_tready drops only when
//   the queue is full, which takes two further frames behind the held result.
//   Reset clears the byte count, crc, queue and output valid; held frame
//   bytes are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module crc8_status_frame_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] chan_code, [15:8] state_byte, [23:16] third_byte, [31:24] relay_bits,
  // [39:32] fourth_byte, [47:40] fifth_byte, [55:48] sixth_byte,
  // [71:56] target_word, [72] valve_flag, [73] hand_mode, [79:74] zero
  output logic [79:0] m_tdata,
  output logic [0:0]  m_tuser    // [0] crc_ok
);
  import crc8sfc_pkg::*;

  q_push_t    q_in;
  frame_rec_t q_rec;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;
  logic       take;

  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;

  crc8sfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .rx_byte     (s_tdata),
    .frame_start (s_tuser[0]),
    .q_in        (q_in)
  );

  crc8sfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .q_in      (q_in),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .rd_rec    (q_rec)
  );

  crc8sfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_rec       (q_rec),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

[rtl/crc8sfc_checker.sv]
// ----------------------------------------------------------------------------
// crc8sfc_checker
// Port-level checks for the status frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module crc8sfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // no result right after reset
  a_idle_after_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // intake stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("intake stalled with no result pending");

  // failed frames carry all-zero fields
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 80'd0)
    else $error("nonzero fields on crc failure");

  // derived fields agree with relay and pump bytes
  a_derived: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[71:64] == m_tdata[31:24] && m_tdata[63:56] == m_tdata[39:32]
      && m_tdata[72] == m_tdata[31] && m_tdata[73] == m_tdata[30])
    else $error("derived fields mismatch");

endmodule

bind crc8_status_frame_checker_top crc8sfc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
